// ===== hdl/spcm_pkg.sv =====
// Shared types and constants for the serpentine pixel channel map.
// Used by every module of the block; depends on nothing.
package spcm_pkg;

  localparam int PIX_W      = 10;
  localparam int DIM_W      = 11;
  localparam int CPN_W      = 3;
  localparam int OFS_W      = 22;
  localparam int COMPONENTS = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // remainder pipeline: bits of the dividend resolved per stage
  localparam int REM_STEPS  = 2;
  localparam int REM_STAGES = PIX_W / REM_STEPS;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRANDS_PER_STRING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_MODE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_TOP          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEFT         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_PER_NODE  = 3'd6;

  // component slots
  localparam int COMP_RED   = 0;
  localparam int COMP_GREEN = 1;
  localparam int COMP_BLUE  = 2;

  // effective (already clamped) configuration
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] sps;
    logic             vertical;
    logic             start_top;
    logic             start_left;
    logic [CPN_W-1:0] cpn;
  } spcm_cfg_t;

  // request payload as it moves through the remainder pipeline
  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [DIM_W-1:0] rem;
  } spcm_item_t;

endpackage

// ===== hdl/spcm_rem_step.sv =====
// One stage of the pipelined strand-index remainder (index mod strands).
// Depends on spcm_pkg.
module spcm_rem_step #(
  parameter int TOP_BIT = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spcm_pkg::spcm_cfg_t   cfg,
  input  logic                  up_valid,
  input  spcm_pkg::spcm_item_t  up_item,
  output logic                  up_ready,
  output logic                  dn_valid,
  output spcm_pkg::spcm_item_t  dn_item,
  input  logic                  dn_ready
);
  import spcm_pkg::*;

  logic             valid_r;
  spcm_item_t       item_r;
  spcm_item_t       item_nxt;
  logic [PIX_W-1:0] dividend;
  logic [DIM_W-1:0] rem_v;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  // restoring remainder, one dividend bit per step
  always_comb begin
    dividend = cfg.vertical ? up_item.x : up_item.y;
    rem_v    = up_item.rem;
    for (int s = 0; s < REM_STEPS; s++) begin
      rem_v = {rem_v[DIM_W-2:0], dividend[TOP_BIT-s]};
      if (rem_v >= cfg.sps) begin
        rem_v = rem_v - cfg.sps;
      end
    end
    item_nxt     = up_item;
    item_nxt.rem = rem_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== hdl/spcm_node_map.sv =====
// Orientation, node index and channel offset stages, ending in the output register.
// Depends on spcm_pkg.
module spcm_node_map (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spcm_pkg::spcm_cfg_t          cfg,
  input  logic                         up_valid,
  input  spcm_pkg::spcm_item_t         up_item,
  output logic                         up_ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_in_range,
  output logic [spcm_pkg::OFS_W-1:0]   out_red_offset,
  output logic                         out_red_used,
  output logic [spcm_pkg::OFS_W-1:0]   out_green_offset,
  output logic                         out_green_used,
  output logic [spcm_pkg::OFS_W-1:0]   out_blue_offset,
  output logic                         out_blue_used
);
  import spcm_pkg::*;

  // stage A: orientation
  logic               a_valid_r;
  logic               a_in_range_r;
  logic [DIM_W-1:0]   a_mul_l_r;
  logic [DIM_W-1:0]   a_mul_r_r;
  logic [DIM_W-1:0]   a_add_r;
  logic               a_in_range_nxt;
  logic [DIM_W-1:0]   a_mul_l_nxt;
  logic [DIM_W-1:0]   a_mul_r_nxt;
  logic [DIM_W-1:0]   a_add_nxt;
  logic [DIM_W-1:0]   x_ext;
  logic [DIM_W-1:0]   y_ext;
  logic [DIM_W-1:0]   x_rev;
  logic [DIM_W-1:0]   y_rev;
  logic               seg_odd;
  logic               a_ready;

  // stage B: node index
  logic               b_valid_r;
  logic               b_in_range_r;
  logic [OFS_W-1:0]   b_node_r;
  logic [2*DIM_W-1:0] b_prod;
  logic [OFS_W-1:0]   b_node_nxt;
  logic               b_ready;

  // stage C: output register
  logic                    out_valid_r;
  logic                    c_in_range_r;
  logic [OFS_W-1:0]        c_ofs_r [COMPONENTS];
  logic [COMPONENTS-1:0]   c_used_r;
  logic [OFS_W+CPN_W-1:0]  c_scaled;
  logic [OFS_W-1:0]        c_ofs_nxt [COMPONENTS];
  logic [COMPONENTS-1:0]   c_used_nxt;
  logic                    c_ready;

  assign c_ready  = !out_valid_r || !out_stall;
  assign b_ready  = !b_valid_r || c_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign up_ready = a_ready;

  always_comb begin
    x_ext          = DIM_W'(up_item.x);
    y_ext          = DIM_W'(up_item.y);
    x_rev          = cfg.width - x_ext - DIM_W'(1);
    y_rev          = cfg.height - y_ext - DIM_W'(1);
    seg_odd        = up_item.rem[0];
    a_in_range_nxt = (x_ext < cfg.width) && (y_ext < cfg.height);
    if (cfg.vertical) begin
      a_mul_l_nxt = cfg.start_left ? x_ext : x_rev;
      a_mul_r_nxt = cfg.height;
      a_add_nxt   = (cfg.start_top == seg_odd) ? y_rev : y_ext;
    end else begin
      a_mul_l_nxt = cfg.start_top ? y_ext : y_rev;
      a_mul_r_nxt = cfg.width;
      a_add_nxt   = (cfg.start_left == seg_odd) ? x_rev : x_ext;
    end
  end

  always_comb begin
    b_prod     = (2*DIM_W)'(a_mul_l_r) * (2*DIM_W)'(a_mul_r_r);
    b_node_nxt = OFS_W'(b_prod) + OFS_W'(a_add_r);
  end

  always_comb begin
    c_scaled = (OFS_W+CPN_W)'(b_node_r) * (OFS_W+CPN_W)'(cfg.cpn);
    for (int k = 0; k < COMPONENTS; k++) begin
      c_used_nxt[k] = b_in_range_r && (CPN_W'(k) < cfg.cpn);
      c_ofs_nxt[k]  = c_used_nxt[k] ? (c_scaled[OFS_W-1:0] + OFS_W'(k)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= up_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      if (c_ready) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_in_range_r <= a_in_range_nxt;
      a_mul_l_r    <= a_mul_l_nxt;
      a_mul_r_r    <= a_mul_r_nxt;
      a_add_r      <= a_add_nxt;
    end
    if (b_ready && a_valid_r) begin
      b_in_range_r <= a_in_range_r;
      b_node_r     <= b_node_nxt;
    end
    if (c_ready && b_valid_r) begin
      c_in_range_r <= b_in_range_r;
      c_used_r     <= c_used_nxt;
      for (int k = 0; k < COMPONENTS; k++) begin
        c_ofs_r[k] <= c_ofs_nxt[k];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_in_range     = c_in_range_r;
  assign out_red_offset   = c_ofs_r[COMP_RED];
  assign out_red_used     = c_used_r[COMP_RED];
  assign out_green_offset = c_ofs_r[COMP_GREEN];
  assign out_green_used   = c_used_r[COMP_GREEN];
  assign out_blue_offset  = c_ofs_r[COMP_BLUE];
  assign out_blue_used    = c_used_r[COMP_BLUE];

endmodule

// ===== hdl/serpentine_pixel_channel_map.sv =====
// Serpentine pixel channel map: pixel (x, y) to RGB channel offsets on a zigzag LED matrix.
// Pipeline: 5 remainder stages, then 3 map stages, from request accept to result valid.
// Throughput: one request per cycle while nothing stalls; the strand-index remainder is a 5-stage pipeline
// resolving 2 dividend bits per stage, the node index takes one 11x11 multiply stage.
// Reset (rst_n, synchronous, active low) empties the pipeline and restores registers to
// width 1, height 1, 1 strand per string, horizontal, top-left start, 3 channels per node.
module serpentine_pixel_channel_map #(
  parameter int MAX_WIDTH  = spcm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = spcm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_wr_en,
  input  logic [spcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spcm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // pixel requests
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [spcm_pkg::PIX_W-1:0]       in_pixel_x,
  input  logic [spcm_pkg::PIX_W-1:0]       in_pixel_y,
  // channel map results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_in_range,
  output logic [spcm_pkg::OFS_W-1:0]       out_red_offset,
  output logic                             out_red_used,
  output logic [spcm_pkg::OFS_W-1:0]       out_green_offset,
  output logic                             out_green_used,
  output logic [spcm_pkg::OFS_W-1:0]       out_blue_offset,
  output logic                             out_blue_used
);
  import spcm_pkg::*;

  // compare width wide enough for both the register and the size limits
  localparam int LIM_W = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int CMP_W = (LIM_W > DIM_W) ? LIM_W : DIM_W;

  // configuration registers, stored as written
  logic [DIM_W-1:0] grid_width_r;
  logic [DIM_W-1:0] grid_height_r;
  logic [DIM_W-1:0] strands_r;
  logic             vertical_mode_r;
  logic             start_top_r;
  logic             start_left_r;
  logic [CPN_W-1:0] cpn_r;

  spcm_cfg_t cfg_eff;

  // remainder pipeline links: entry g feeds stage g
  logic [REM_STAGES:0] rem_valid;
  logic [REM_STAGES:0] rem_ready;
  spcm_item_t          rem_item [REM_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r    <= DIM_W'(1);
      grid_height_r   <= DIM_W'(1);
      strands_r       <= DIM_W'(1);
      vertical_mode_r <= 1'b0;
      start_top_r     <= 1'b1;
      start_left_r    <= 1'b1;
      cpn_r           <= CPN_W'(3);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:         grid_width_r    <= cfg_wdata;
        REG_GRID_HEIGHT:        grid_height_r   <= cfg_wdata;
        REG_STRANDS_PER_STRING: strands_r       <= cfg_wdata;
        REG_VERTICAL_MODE:      vertical_mode_r <= cfg_wdata[0];
        REG_START_TOP:          start_top_r     <= cfg_wdata[0];
        REG_START_LEFT:         start_left_r    <= cfg_wdata[0];
        REG_CHANNELS_PER_NODE:  cpn_r           <= cfg_wdata[CPN_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Clamp sizes once here; zero sizes act as one, oversize grids are
  // limited to the build-time maximum. The user must change registers only
  // while idle (the block does not enforce it), so every stage can read these directly.
  always_comb begin
    cfg_eff.width = grid_width_r;
    if (grid_width_r == '0) begin
      cfg_eff.width = DIM_W'(1);
    end else if (CMP_W'(grid_width_r) > CMP_W'(MAX_WIDTH)) begin
      cfg_eff.width = DIM_W'(MAX_WIDTH);
    end
    cfg_eff.height = grid_height_r;
    if (grid_height_r == '0) begin
      cfg_eff.height = DIM_W'(1);
    end else if (CMP_W'(grid_height_r) > CMP_W'(MAX_HEIGHT)) begin
      cfg_eff.height = DIM_W'(MAX_HEIGHT);
    end
    cfg_eff.sps        = (strands_r == '0) ? DIM_W'(1) : strands_r;
    cfg_eff.vertical   = vertical_mode_r;
    cfg_eff.start_top  = start_top_r;
    cfg_eff.start_left = start_left_r;
    cfg_eff.cpn        = (cpn_r == '0) ? CPN_W'(1) : cpn_r;
  end

  // Requests enter the first remainder stage directly; stall only when
  // that stage is full and cannot advance.
  assign rem_valid[0]     = in_valid;
  assign rem_item[0].x    = in_pixel_x;
  assign rem_item[0].y    = in_pixel_y;
  assign rem_item[0].rem  = '0;
  assign in_stall         = !rem_ready[0];

  // strand index mod strands_per_string, MSB first, two bits per stage
  for (genvar g = 0; g < REM_STAGES; g++) begin : g_rem
    spcm_rem_step #(
      .TOP_BIT (PIX_W - 1 - g * REM_STEPS)
    ) u_rem_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg      (cfg_eff),
      .up_valid (rem_valid[g]),
      .up_item  (rem_item[g]),
      .up_ready (rem_ready[g]),
      .dn_valid (rem_valid[g+1]),
      .dn_item  (rem_item[g+1]),
      .dn_ready (rem_ready[g+1])
    );
  end

  // orientation, node index, per-component offsets and output register
  spcm_node_map u_node_map (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_eff),
    .up_valid         (rem_valid[REM_STAGES]),
    .up_item          (rem_item[REM_STAGES]),
    .up_ready         (rem_ready[REM_STAGES]),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_in_range     (out_in_range),
    .out_red_offset   (out_red_offset),
    .out_red_used     (out_red_used),
    .out_green_offset (out_green_offset),
    .out_green_used   (out_green_used),
    .out_blue_offset  (out_blue_offset),
    .out_blue_used    (out_blue_used)
  );

endmodule

// ===== hdl/spcm_checker.sv =====
// Port-level checks for serpentine_pixel_channel_map, bound to the top level.
// Depends on spcm_pkg.
module spcm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_in_range,
  input logic [spcm_pkg::OFS_W-1:0]     out_red_offset,
  input logic                           out_red_used,
  input logic [spcm_pkg::OFS_W-1:0]     out_green_offset,
  input logic                           out_green_used,
  input logic [spcm_pkg::OFS_W-1:0]     out_blue_offset,
  input logic                           out_blue_used
);
  import spcm_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_offset)
      && $stable(out_green_offset) && $stable(out_blue_offset)
      && $stable(out_in_range))
    else $error("stalled result changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // outside the grid everything is zero
  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> !out_red_used && !out_green_used && !out_blue_used
      && out_red_offset == '0 && out_green_offset == '0 && out_blue_offset == '0)
    else $error("out-of-range pixel with nonzero map");

  // components are used in order and red always when in range
  a_used_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_in_range == out_red_used) && (!out_green_used || out_red_used)
      && (!out_blue_used || out_green_used))
    else $error("component used flags out of order");

  // a used green component takes the channel right after red
  a_consecutive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_green_used |-> out_green_offset == OFS_W'(out_red_offset + OFS_W'(1)))
    else $error("green offset does not follow red");

endmodule

bind serpentine_pixel_channel_map spcm_checker u_spcm_checker (.*);
